// File: hw/rtl/cposp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cposp_pkg
// types, codes and character tables shared by the odc cpio stream parser
// ----------------------------------------------------------------------------
package cposp_pkg;

   typedef enum logic [2:0] {
      PHASE_MAGIC  = 3'd0,
      PHASE_HEADER = 3'd1,
      PHASE_NAME   = 3'd2,
      PHASE_DATA   = 3'd3,
      PHASE_HALT   = 3'd4
   } phase_type;

   localparam logic [2:0] ROLE_MAGIC   = 3'd0;
   localparam logic [2:0] ROLE_DIGIT   = 3'd1;
   localparam logic [2:0] ROLE_NAME    = 3'd2;
   localparam logic [2:0] ROLE_DATA    = 3'd3;
   localparam logic [2:0] ROLE_IGNORED = 3'd4;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_BAD_MAGIC   = 2'd1;
   localparam logic [1:0] ERR_NAME_LENGTH = 2'd2;

   localparam logic [3:0] FIELD_DEV      = 4'd0;
   localparam logic [3:0] FIELD_MTIME    = 4'd7;
   localparam logic [3:0] FIELD_NAMESIZE = 4'd8;
   localparam logic [3:0] FIELD_FILESIZE = 4'd9;

   localparam logic [17:0] MAX_NAME_LENGTH_RESET = 18'd1024;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_SEVEN = 8'h37;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  data_byte;
      logic        field_done;
      logic [3:0]  field_index;
      logic [32:0] field_value;
      logic        name_last;
      logic        entry_ready;
      logic        data_last;
      logic        trailer_seen;
      logic [1:0]  error_code;
   } result_type;

   // "070707"
   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0, 3'd2, 3'd4: c = 8'h30;
         3'd1, 3'd3, 3'd5: c = 8'h37;
         default:          c = 8'h00;
      endcase
      return c;
   endfunction

   // "TRAILER!!!"
   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:             c = 8'h54;
         4'd1:             c = 8'h52;
         4'd2:             c = 8'h41;
         4'd3:             c = 8'h49;
         4'd4:             c = 8'h4C;
         4'd5:             c = 8'h45;
         4'd6:             c = 8'h52;
         4'd7, 4'd8, 4'd9: c = 8'h21;
         default:          c = 8'h00;
      endcase
      return c;
   endfunction

   // digits per header field
   function automatic logic [3:0] field_len(input logic [3:0] idx);
      logic [3:0] n;
      case (idx)
         FIELD_MTIME, FIELD_FILESIZE: n = 4'd11;
         default:                     n = 4'd6;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cposp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cposp_parse_core
// per-byte parser state machine: magic check, octal field accumulation,
// name and trailer tracking, data byte counting, sticky error and trailer
// ----------------------------------------------------------------------------
module cposp_parse_core
   import cposp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  in_byte,
   input  wire logic        csr_wr_en,
   input  wire logic [17:0] csr_wr_data,
   output result_type       result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  field_num_ff, field_num_in;
   logic [32:0] pos_ff, pos_in;
   logic [32:0] acc_ff, acc_in;
   logic [17:0] name_size_ff, name_size_in;
   logic [32:0] data_size_ff, data_size_in;
   logic        trailer_match_ff, trailer_match_in;
   logic [1:0]  error_ff, error_in;
   logic        trailer_done_ff, trailer_done_in;
   logic [17:0] max_name_ff;

   logic [33:0] pos_inc;
   logic [3:0]  fn;
   logic [2:0]  digit;
   logic [32:0] acc_shift;
   logic [32:0] field_val;
   logic        last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_MAGIC;
         field_num_ff     <= FIELD_DEV;
         pos_ff           <= '0;
         acc_ff           <= '0;
         name_size_ff     <= '0;
         data_size_ff     <= '0;
         trailer_match_ff <= 1'b1;
         error_ff         <= ERR_NONE;
         trailer_done_ff  <= 1'b0;
         max_name_ff      <= MAX_NAME_LENGTH_RESET;
      end else begin
         if (step) begin
            phase_ff         <= phase_in;
            field_num_ff     <= field_num_in;
            pos_ff           <= pos_in;
            acc_ff           <= acc_in;
            name_size_ff     <= name_size_in;
            data_size_ff     <= data_size_in;
            trailer_match_ff <= trailer_match_in;
            error_ff         <= error_in;
            trailer_done_ff  <= trailer_done_in;
         end
         if (csr_wr_en) begin
            max_name_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      pos_inc   = {1'b0, pos_ff} + 34'd1;
      fn        = (field_num_ff > FIELD_FILESIZE) ? FIELD_FILESIZE : field_num_ff;
      digit     = (in_byte >= CHAR_ZERO && in_byte <= CHAR_SEVEN) ? in_byte[2:0] : 3'd0;
      acc_shift = {acc_ff[29:0], digit};
      field_val = (fn == FIELD_MTIME) ? {1'b0, acc_shift[31:0]} : acc_shift;
      last      = (pos_inc >= {16'd0, name_size_ff});

      phase_in         = phase_ff;
      field_num_in     = field_num_ff;
      pos_in           = pos_ff;
      acc_in           = acc_ff;
      name_size_in     = name_size_ff;
      data_size_in     = data_size_ff;
      trailer_match_in = trailer_match_ff;
      error_in         = error_ff;
      trailer_done_in  = trailer_done_ff;

      result             = '0;
      result.byte_role   = ROLE_IGNORED;
      result.data_byte   = in_byte;

      case (phase_ff)
         PHASE_MAGIC: begin
            result.byte_role = ROLE_MAGIC;
            if (pos_ff >= 33'd6 || in_byte != magic_char(pos_ff[2:0])) begin
               error_in = ERR_BAD_MAGIC;
               phase_in = PHASE_HALT;
            end else if (pos_ff == 33'd5) begin
               phase_in     = PHASE_HEADER;
               pos_in       = '0;
               field_num_in = FIELD_DEV;
               acc_in       = '0;
            end else begin
               pos_in = pos_inc[32:0];
            end
         end
         PHASE_HEADER: begin
            result.byte_role = ROLE_DIGIT;
            acc_in = acc_shift;
            pos_in = pos_inc[32:0];
            if (pos_inc >= {30'd0, field_len(fn)}) begin
               result.field_done  = 1'b1;
               result.field_index = fn;
               result.field_value = field_val;
               acc_in = '0;
               pos_in = '0;
               if (fn == FIELD_NAMESIZE) begin
                  name_size_in = field_val[17:0];
               end
               if (fn == FIELD_FILESIZE) begin
                  data_size_in = field_val;
                  if (name_size_ff == 18'd0 || name_size_ff > max_name_ff) begin
                     error_in = ERR_NAME_LENGTH;
                     phase_in = PHASE_HALT;
                  end else begin
                     phase_in         = PHASE_NAME;
                     trailer_match_in = 1'b1;
                  end
               end else begin
                  field_num_in = fn + 4'd1;
               end
            end
         end
         PHASE_NAME: begin
            result.byte_role = ROLE_NAME;
            if (pos_ff < 33'd10) begin
               if (in_byte != trailer_char(pos_ff[3:0])) begin
                  trailer_match_in = 1'b0;
               end
            end else if (pos_ff == 33'd10) begin
               if (in_byte != 8'd0 && !last) begin
                  trailer_match_in = 1'b0;
               end
            end
            if (last) begin
               result.name_last = 1'b1;
               if (trailer_match_in && pos_ff >= 33'd10) begin
                  trailer_done_in = 1'b1;
                  phase_in        = PHASE_HALT;
               end else begin
                  result.entry_ready = 1'b1;
                  pos_in             = '0;
                  if (data_size_ff != 33'd0) begin
                     phase_in = PHASE_DATA;
                  end else begin
                     phase_in     = PHASE_MAGIC;
                     field_num_in = FIELD_DEV;
                     acc_in       = '0;
                  end
               end
            end else begin
               pos_in = pos_inc[32:0];
            end
         end
         PHASE_DATA: begin
            result.byte_role = ROLE_DATA;
            if (pos_inc >= {1'b0, data_size_ff}) begin
               result.data_last = 1'b1;
               phase_in         = PHASE_MAGIC;
               pos_in           = '0;
               field_num_in     = FIELD_DEV;
               acc_in           = '0;
            end else begin
               pos_in = pos_inc[32:0];
            end
         end
         default: begin
            result.byte_role = ROLE_IGNORED;
         end
      endcase

      result.trailer_seen = trailer_done_in;
      result.error_code   = error_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/cposp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cposp_out_reg
// result register holding one transaction towards the downstream side
// ----------------------------------------------------------------------------
module cposp_out_reg
   import cposp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  result_type load_data,
   input  wire logic out_stall,
   output logic      out_valid,
   output result_type out_data,
   output logic      busy
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign busy      = valid_ff & out_stall;

endmodule
`default_nettype wire

// File: hw/rtl/cpio_odc_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// result: each accepted byte yields a registered result transaction in the next cycle
// throughput: one byte per cycle; the state update and the result register
//    stage sustain a new transaction every clock while the result is taken
// reset: synchronous, active high; parser returns to expecting magic,
//    errors and trailer clear, max_name_length returns to 1024
// ----------------------------------------------------------------------------
// cpio_odc_stream_parser
// byte-serial old-portable cpio header parser with role tagging per byte
// ----------------------------------------------------------------------------
module cpio_odc_stream_parser
   import cposp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_byte_role,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_field_done,
   output logic [3:0]       rsp_field_index,
   output logic [32:0]      rsp_field_value,
   output logic             rsp_name_last,
   output logic             rsp_entry_ready,
   output logic             rsp_data_last,
   output logic             rsp_trailer_seen,
   output logic [1:0]       rsp_error_code,
   input  wire logic        csr_wr_en,
   input  wire logic [17:0] csr_wr_data
);

   logic       accept;
   logic       busy;
   result_type core_result;
   result_type out_result;

   assign req_stall = busy;
   assign accept    = req_valid & ~busy;

   cposp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .in_byte     (req_in_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (core_result)
   );

   cposp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (core_result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_result),
      .busy      (busy)
   );

   assign rsp_byte_role    = out_result.byte_role;
   assign rsp_data_byte    = out_result.data_byte;
   assign rsp_field_done   = out_result.field_done;
   assign rsp_field_index  = out_result.field_index;
   assign rsp_field_value  = out_result.field_value;
   assign rsp_name_last    = out_result.name_last;
   assign rsp_entry_ready  = out_result.entry_ready;
   assign rsp_data_last    = out_result.data_last;
   assign rsp_trailer_seen = out_result.trailer_seen;
   assign rsp_error_code   = out_result.error_code;

endmodule
`default_nettype wire
